// ----- src/sgpm_pkg.sv -----
// ----------------------------------------------------------------------------
// sgpm_pkg: shared types, constants and helpers for the stereo gain/pan mixer
// Sequencer states, datapath widths, accumulator and output saturation.
// ----------------------------------------------------------------------------
package sgpm_pkg;

  localparam int MAX_SOURCES = 16;          // sources per frame before forced close
  localparam int SAMPLE_BITS = 24;          // sample / mix word width
  localparam int CNT_W       = $clog2(MAX_SOURCES);
  localparam int GAIN_W      = 16;
  localparam int PAN_W       = 16;
  localparam int WGT_W       = 16;          // pan weight, unsigned Q1.15, 0..32768
  localparam int GW_W        = 32;          // gain * weight, unsigned
  localparam int MUL_A_W     = SAMPLE_BITS + 1;
  localparam int MUL_B_W     = GW_W + 1;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
  localparam int PROD_W      = SAMPLE_BITS + GW_W;  // signed product, fits with margin
  localparam int PROD_SHIFT  = 27;
  localparam int TERM_W      = PROD_W - PROD_SHIFT;
  localparam int ACC_W       = 40;

  localparam logic signed [PAN_W-1:0] PAN_LIMIT = 16'sd16384;
  localparam logic [WGT_W-1:0]        UNITY_Q15 = 16'd32768;
  localparam logic signed [PROD_W-1:0] RND_HALF =
    PROD_W'(64'sd1 <<< (PROD_SHIFT - 1));
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] OUT_MAX =
    ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] OUT_MIN = ACC_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN_L,
    ST_GAIN_R,
    ST_PROD_L,
    ST_PROD_R,
    ST_ACC_R,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          clip;
  } sat_t;

  // Round product to Q6.23 (half up) and add into accumulator, saturating.
  function automatic logic signed [ACC_W-1:0] acc_add(
    input logic signed [ACC_W-1:0]  acc,
    input logic signed [PROD_W-1:0] prod
  );
    logic signed [PROD_W-1:0] rnd;
    logic signed [TERM_W-1:0] term;
    logic signed [ACC_W:0]    sum;
    rnd  = prod + RND_HALF;
    term = rnd[PROD_W-1:PROD_SHIFT];
    sum  = {acc[ACC_W-1], acc} + {{(ACC_W+1-TERM_W){term[TERM_W-1]}}, term};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_add = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_add = sum[ACC_W-1:0];
    end
  endfunction

  // Clamp accumulator to sample width.
  function automatic sat_t sat_out(input logic signed [ACC_W-1:0] v);
    sat_t res;
    if (v > OUT_MAX) begin
      res.value = OUT_MAX[SAMPLE_BITS-1:0];
      res.clip  = 1'b1;
    end else if (v < OUT_MIN) begin
      res.value = OUT_MIN[SAMPLE_BITS-1:0];
      res.clip  = 1'b1;
    end else begin
      res.value = v[SAMPLE_BITS-1:0];
      res.clip  = 1'b0;
    end
    sat_out = res;
  endfunction

endpackage

// ----- src/stereo_gain_pan_mixer.sv -----
// ----------------------------------------------------------------------------
// stereo_gain_pan_mixer: stereo source mixer with linear gain and pan
// Weights each source pair by gain and pan, sums into two 40-bit
// accumulators and emits the saturated mix when a frame closes.
// ----------------------------------------------------------------------------
//
//  channel | ports                                             | dir
//  --------+---------------------------------------------------+-----
//  in      | in_valid, in_stall, in_left_sample, in_right_sample,| in
//          | in_source_gain, in_pan_amount, in_last_source     |
//  out     | out_valid, out_stall, out_mix_left, out_mix_right,| out
//          | out_clipped                                       |
//
//  An input word is accepted in idle, then runs five steps of the
//  sequencer around the single shared 25x33 multiplier (two gain*weight
//  products, two sample products, the last accumulate). A frame-closing
//  word adds an emit step, which waits while the output register is held.
//  rst_n (synchronous) clears the accumulators, source count and valids.
//  in_stall is high whenever the sequencer is busy; out_stall only holds
//  the output register and, on a close, the emit step.
//
module stereo_gain_pan_mixer (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [sgpm_pkg::SAMPLE_BITS-1:0] in_left_sample,
  input  logic signed [sgpm_pkg::SAMPLE_BITS-1:0] in_right_sample,
  input  logic        [sgpm_pkg::GAIN_W-1:0]      in_source_gain,
  input  logic signed [sgpm_pkg::PAN_W-1:0]       in_pan_amount,
  input  logic                                    in_last_source,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [sgpm_pkg::SAMPLE_BITS-1:0] out_mix_left,
  output logic signed [sgpm_pkg::SAMPLE_BITS-1:0] out_mix_right,
  output logic                                    out_clipped
);

  // sequencer and control
  sgpm_pkg::state_t                 state_r, state_nxt;
  logic [sgpm_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                             close_r, close_nxt;

  // latched input word
  logic signed [sgpm_pkg::SAMPLE_BITS-1:0] ls_r, ls_nxt;
  logic signed [sgpm_pkg::SAMPLE_BITS-1:0] rs_r, rs_nxt;
  logic [sgpm_pkg::GAIN_W-1:0]             gain_r, gain_nxt;
  logic [sgpm_pkg::WGT_W-1:0]              wr_r, wr_nxt;   // right weight f
  logic [sgpm_pkg::WGT_W-1:0]              wl_r, wl_nxt;   // left weight 1-f

  // intermediate products
  logic [sgpm_pkg::GW_W-1:0]          gwl_r, gwl_nxt;
  logic [sgpm_pkg::GW_W-1:0]          gwr_r, gwr_nxt;
  logic signed [sgpm_pkg::PROD_W-1:0] prod_r, prod_nxt;

  // accumulators
  logic signed [sgpm_pkg::ACC_W-1:0] accl_r, accl_nxt;
  logic signed [sgpm_pkg::ACC_W-1:0] accr_r, accr_nxt;

  // output register
  logic                                    ovalid_r, ovalid_nxt;
  logic signed [sgpm_pkg::SAMPLE_BITS-1:0] omixl_r, omixl_nxt;
  logic signed [sgpm_pkg::SAMPLE_BITS-1:0] omixr_r, omixr_nxt;
  logic                                    oclip_r, oclip_nxt;

  // shared multiplier
  logic signed [sgpm_pkg::MUL_A_W-1:0] mul_a;
  logic signed [sgpm_pkg::MUL_B_W-1:0] mul_b;
  logic signed [sgpm_pkg::MUL_P_W-1:0] mul_p;

  logic                       in_acc;
  logic                       out_free;
  logic signed [sgpm_pkg::PAN_W-1:0] pan_c;
  sgpm_pkg::sat_t             sat_l, sat_r;

  assign in_stall = (state_r != sgpm_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !ovalid_r || !out_stall;

  assign out_valid     = ovalid_r;
  assign out_mix_left  = omixl_r;
  assign out_mix_right = omixr_r;
  assign out_clipped   = oclip_r;

  assign sat_l = sgpm_pkg::sat_out(accl_r);
  assign sat_r = sgpm_pkg::sat_out(accr_r);

  // pan clamp to full left / full right
  always_comb begin
    priority if (in_pan_amount > sgpm_pkg::PAN_LIMIT) begin
      pan_c = sgpm_pkg::PAN_LIMIT;
    end else if (in_pan_amount < -sgpm_pkg::PAN_LIMIT) begin
      pan_c = -sgpm_pkg::PAN_LIMIT;
    end else begin
      pan_c = in_pan_amount;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    unique case (state_r)
      sgpm_pkg::ST_GAIN_L: begin
        mul_a = sgpm_pkg::MUL_A_W'(gain_r);
        mul_b = sgpm_pkg::MUL_B_W'(wl_r);
      end
      sgpm_pkg::ST_GAIN_R: begin
        mul_a = sgpm_pkg::MUL_A_W'(gain_r);
        mul_b = sgpm_pkg::MUL_B_W'(wr_r);
      end
      sgpm_pkg::ST_PROD_L: begin
        mul_a = {ls_r[sgpm_pkg::SAMPLE_BITS-1], ls_r};
        mul_b = {1'b0, gwl_r};
      end
      sgpm_pkg::ST_PROD_R: begin
        mul_a = {rs_r[sgpm_pkg::SAMPLE_BITS-1], rs_r};
        mul_b = {1'b0, gwr_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // next state and datapath
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    close_nxt  = close_r;
    ls_nxt     = ls_r;
    rs_nxt     = rs_r;
    gain_nxt   = gain_r;
    wr_nxt     = wr_r;
    wl_nxt     = wl_r;
    gwl_nxt    = gwl_r;
    gwr_nxt    = gwr_r;
    prod_nxt   = prod_r;
    accl_nxt   = accl_r;
    accr_nxt   = accr_r;
    ovalid_nxt = ovalid_r && out_stall;
    omixl_nxt  = omixl_r;
    omixr_nxt  = omixr_r;
    oclip_nxt  = oclip_r;

    unique case (state_r)
      sgpm_pkg::ST_IDLE: begin
        if (in_acc) begin
          ls_nxt    = in_left_sample;
          rs_nxt    = in_right_sample;
          gain_nxt  = in_source_gain;
          wr_nxt    = sgpm_pkg::WGT_W'(pan_c + sgpm_pkg::PAN_LIMIT);
          wl_nxt    = sgpm_pkg::UNITY_Q15 - sgpm_pkg::WGT_W'(pan_c + sgpm_pkg::PAN_LIMIT);
          // frame closes on the mark or on the last allowed source
          close_nxt = in_last_source ||
                      (cnt_r == sgpm_pkg::CNT_W'(sgpm_pkg::MAX_SOURCES - 1));
          cnt_nxt   = close_nxt ? '0 : cnt_r + 1'b1;
          state_nxt = sgpm_pkg::ST_GAIN_L;
        end
      end
      sgpm_pkg::ST_GAIN_L: begin
        prod_nxt  = mul_p[sgpm_pkg::PROD_W-1:0];
        state_nxt = sgpm_pkg::ST_GAIN_R;
      end
      sgpm_pkg::ST_GAIN_R: begin
        gwl_nxt   = prod_r[sgpm_pkg::GW_W-1:0];
        prod_nxt  = mul_p[sgpm_pkg::PROD_W-1:0];
        state_nxt = sgpm_pkg::ST_PROD_L;
      end
      sgpm_pkg::ST_PROD_L: begin
        gwr_nxt   = prod_r[sgpm_pkg::GW_W-1:0];
        prod_nxt  = mul_p[sgpm_pkg::PROD_W-1:0];
        state_nxt = sgpm_pkg::ST_PROD_R;
      end
      sgpm_pkg::ST_PROD_R: begin
        accl_nxt  = sgpm_pkg::acc_add(accl_r, prod_r);
        prod_nxt  = mul_p[sgpm_pkg::PROD_W-1:0];
        state_nxt = sgpm_pkg::ST_ACC_R;
      end
      sgpm_pkg::ST_ACC_R: begin
        accr_nxt  = sgpm_pkg::acc_add(accr_r, prod_r);
        state_nxt = close_r ? sgpm_pkg::ST_EMIT : sgpm_pkg::ST_IDLE;
      end
      sgpm_pkg::ST_EMIT: begin
        // wait until the output register can take the mix word
        if (out_free) begin
          ovalid_nxt = 1'b1;
          omixl_nxt  = sat_l.value;
          omixr_nxt  = sat_r.value;
          oclip_nxt  = sat_l.clip || sat_r.clip;
          accl_nxt   = '0;
          accr_nxt   = '0;
          state_nxt  = sgpm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sgpm_pkg::ST_IDLE;
      end
    endcase
  end

  // control and accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sgpm_pkg::ST_IDLE;
      cnt_r    <= '0;
      close_r  <= 1'b0;
      accl_r   <= '0;
      accr_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      close_r  <= close_nxt;
      accl_r   <= accl_nxt;
      accr_r   <= accr_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ls_r    <= ls_nxt;
    rs_r    <= rs_nxt;
    gain_r  <= gain_nxt;
    wr_r    <= wr_nxt;
    wl_r    <= wl_nxt;
    gwl_r   <= gwl_nxt;
    gwr_r   <= gwr_nxt;
    prod_r  <= prod_nxt;
    omixl_r <= omixl_nxt;
    omixr_r <= omixr_nxt;
    oclip_r <= oclip_nxt;
  end

  // a new mix word only ever comes out of the emit step
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !$past(ovalid_r && out_stall)) |-> $past(state_r) == sgpm_pkg::ST_EMIT)
    else $error("mix word appeared outside emit step");

  // accumulators are cleared once a frame is emitted
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sgpm_pkg::ST_EMIT && out_free) |=> (accl_r == '0 && accr_r == '0))
    else $error("accumulators not cleared after emit");

  // an accepted word always starts the multiply sequence
  a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == sgpm_pkg::ST_GAIN_L)
    else $error("sequencer did not start on accepted word");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for stereo_gain_pan_mixer
// Feeds source words on the input channel, predicts each mixed frame from
// its own model of the gain/pan accumulators and checks every output word.
// ----------------------------------------------------------------------------
module tb;

  localparam int      CYCLE_LIMIT = 400000;  // several times the slowest legal run
  localparam int      N_RANDOM    = 1850;    // random source words after the directed set
  localparam int      TAIL_WORDS  = 150;     // final words run with no idling
  localparam int      HOLD_AT     = 300;     // long receiver hold-off starts here
  localparam int      HOLD_CYCLES = 600;
  localparam int      DRAIN_AT    = 1000;    // sender pauses for a full drain here
  localparam int      SETTLE      = 20;      // cycles after the last mix word

  localparam logic signed [sgpm_pkg::SAMPLE_BITS-1:0] S_MAX =
    {1'b0, {(sgpm_pkg::SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [sgpm_pkg::SAMPLE_BITS-1:0] S_MIN =
    {1'b1, {(sgpm_pkg::SAMPLE_BITS-1){1'b0}}};
  localparam longint PAN_LIM  = 16384;
  localparam longint UNITY    = 32768;
  localparam longint ACC_HI   = (64'sd1 <<< (sgpm_pkg::ACC_W - 1)) - 1;
  localparam longint ACC_LO   = -ACC_HI - 1;
  localparam longint MIX_HI   = (64'sd1 <<< (sgpm_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint MIX_LO   = -MIX_HI - 1;

  // one source word as offered on the input channel
  typedef struct {
    logic signed [sgpm_pkg::SAMPLE_BITS-1:0] ls;
    logic signed [sgpm_pkg::SAMPLE_BITS-1:0] rs;
    logic        [sgpm_pkg::GAIN_W-1:0]      gain;
    logic signed [sgpm_pkg::PAN_W-1:0]       pan;
    logic                                    last;
  } source_word_t;

  // one mixed frame as expected on the output channel
  typedef struct {
    logic signed [sgpm_pkg::SAMPLE_BITS-1:0] left;
    logic signed [sgpm_pkg::SAMPLE_BITS-1:0] right;
    logic                                    clip;
  } mix_word_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                                    in_valid        = 1'b0;
  logic                                    in_stall;
  logic signed [sgpm_pkg::SAMPLE_BITS-1:0] in_left_sample  = '0;
  logic signed [sgpm_pkg::SAMPLE_BITS-1:0] in_right_sample = '0;
  logic        [sgpm_pkg::GAIN_W-1:0]      in_source_gain  = '0;
  logic signed [sgpm_pkg::PAN_W-1:0]       in_pan_amount   = '0;
  logic                                    in_last_source  = 1'b0;
  logic                                    out_valid;
  logic                                    out_stall       = 1'b0;
  logic signed [sgpm_pkg::SAMPLE_BITS-1:0] out_mix_left;
  logic signed [sgpm_pkg::SAMPLE_BITS-1:0] out_mix_right;
  logic                                    out_clipped;

  stereo_gain_pan_mixer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .in_source_gain  (in_source_gain),
    .in_pan_amount   (in_pan_amount),
    .in_last_source  (in_last_source),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_mix_left    (out_mix_left),
    .out_mix_right   (out_mix_right),
    .out_clipped     (out_clipped)
  );

  always #2 clk = ~clk;

  // stimulus and scoreboard storage
  source_word_t src_words[$];    // words not yet offered
  mix_word_t    mix_expect[$];   // mixed frames predicted, not yet seen

  int total_words = 0;
  int words_taken = 0;           // NBA-updated, shared with other processes
  int mixes_made  = 0;           // predictions pushed (driver only)
  int mixes_seen  = 0;           // output words taken (NBA, monitor)
  int fail_cnt    = 0;
  int cycle_cnt   = 0;

  // ---------------------------------------------------------------------------
  // Mixer model: its own copy of both accumulators and the open-frame count.
  // ---------------------------------------------------------------------------
  longint left_acc  = 0;
  longint right_acc = 0;
  int     frame_srcs = 0;

  // sample * gain * weight, rounded half up from 50 to 23 fraction bits
  function automatic longint weigh(longint s, longint g, longint w);
    longint p;
    p = s * g * w;
    return (p + (64'sd1 <<< (sgpm_pkg::PROD_SHIFT - 1))) >>> sgpm_pkg::PROD_SHIFT;
  endfunction

  function automatic longint acc_sat(longint acc, longint term);
    longint s;
    s = acc + term;
    if (s > ACC_HI) return ACC_HI;
    if (s < ACC_LO) return ACC_LO;
    return s;
  endfunction

  function automatic logic signed [sgpm_pkg::SAMPLE_BITS-1:0] clamp_mix(
    longint v, inout logic clip);
    if (v > MIX_HI) begin
      clip = 1'b1;
      return S_MAX;
    end
    if (v < MIX_LO) begin
      clip = 1'b1;
      return S_MIN;
    end
    return v[sgpm_pkg::SAMPLE_BITS-1:0];
  endfunction

  // Take one accepted source word; returns 1 when it closes a frame and
  // queues the expected mix word.
  function automatic bit mix_source(input source_word_t w);
    longint    pan;
    longint    frac;
    mix_word_t m;
    logic      clip;
    pan = longint'(w.pan);
    // out-of-range pan is pinned to full left / full right
    if (pan > PAN_LIM) pan = PAN_LIM;
    if (pan < -PAN_LIM) pan = -PAN_LIM;
    frac = pan + PAN_LIM;
    left_acc  = acc_sat(left_acc,  weigh(longint'(w.ls), longint'(w.gain), UNITY - frac));
    right_acc = acc_sat(right_acc, weigh(longint'(w.rs), longint'(w.gain), frac));
    frame_srcs++;
    // a frame that runs to MAX_SOURCES closes on its own
    if (!w.last && frame_srcs < sgpm_pkg::MAX_SOURCES) return 1'b0;
    clip    = 1'b0;
    m.left  = clamp_mix(left_acc, clip);
    m.right = clamp_mix(right_acc, clip);
    m.clip  = clip;
    mix_expect.push_back(m);
    left_acc   = 0;
    right_acc  = 0;
    frame_srcs = 0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_word(logic signed [sgpm_pkg::SAMPLE_BITS-1:0] ls,
                          logic signed [sgpm_pkg::SAMPLE_BITS-1:0] rs,
                          logic [sgpm_pkg::GAIN_W-1:0] gain,
                          logic signed [sgpm_pkg::PAN_W-1:0] pan, logic last);
    source_word_t w;
    w.ls = ls; w.rs = rs; w.gain = gain; w.pan = pan; w.last = last;
    src_words.push_back(w);
  endtask

  function automatic logic signed [sgpm_pkg::SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return sgpm_pkg::SAMPLE_BITS'($urandom_range(0, 511)) -
                      sgpm_pkg::SAMPLE_BITS'(256);
      default: return sgpm_pkg::SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [sgpm_pkg::GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return sgpm_pkg::GAIN_W'($urandom);
      default: return sgpm_pkg::GAIN_W'($urandom_range(0, 8192));
    endcase
  endfunction

  function automatic logic signed [sgpm_pkg::PAN_W-1:0] rand_pan();
    case ($urandom_range(0, 7))
      0:       return -sgpm_pkg::PAN_LIMIT;
      1:       return sgpm_pkg::PAN_LIMIT;
      2:       return sgpm_pkg::PAN_W'($urandom);      // often out of range -> clamp
      3:       return '0;
      default: return sgpm_pkg::PAN_W'($urandom_range(0, 32768)) - sgpm_pkg::PAN_LIMIT;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus build, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    int len;
    // directed: field extremes, mostly single-source frames
    add_word(S_MAX, S_MIN, 16'd4096, 16'sd0, 1'b1);                   // unity gain, center
    add_word(S_MIN, S_MAX, 16'hFFFF, -sgpm_pkg::PAN_LIMIT, 1'b1);     // full left, max gain
    add_word(S_MAX, S_MAX, 16'hFFFF, sgpm_pkg::PAN_LIMIT, 1'b0);      // full right
    add_word(S_MAX, S_MAX, 16'hFFFF, 16'sd0, 1'b1);          // positive clip, both sides
    add_word(S_MIN, S_MIN, 16'hFFFF, 16'sh8000, 1'b0);       // pan below range
    add_word(S_MIN, S_MIN, 16'hFFFF, 16'sh8000, 1'b1);       // negative clip
    add_word(S_MAX, S_MIN, 16'hFFFF, 16'sh7FFF, 1'b1);       // pan above range
    add_word(S_MAX, S_MIN, 16'd0, 16'sd123, 1'b1);           // zero gain
    // rounding: exactly half an LSB rounds up, minus half rounds to zero
    add_word(24'sd1, -24'sd1, 16'd2048, -sgpm_pkg::PAN_LIMIT, 1'b1);
    add_word(-24'sd1, 24'sd1, 16'd2048, -sgpm_pkg::PAN_LIMIT, 1'b1);
    add_word(24'sd3, -24'sd3, 16'd4095, 16'sd1, 1'b1);
    // frame that never marks last: closes itself at MAX_SOURCES
    for (int k = 0; k < sgpm_pkg::MAX_SOURCES; k++) begin
      add_word(rand_sample(), rand_sample(), rand_gain(), rand_pan(), 1'b0);
    end
    add_word(S_MIN, S_MAX, 16'd1, 16'sd0, 1'b1);
    // random frames, mostly short; some overrun MAX_SOURCES without a mark
    n = 0;
    while (n < N_RANDOM) begin
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(sgpm_pkg::MAX_SOURCES + 1, sgpm_pkg::MAX_SOURCES + 8);
        1, 2:    len = $urandom_range(9, sgpm_pkg::MAX_SOURCES);
        default: len = $urandom_range(1, 8);
      endcase
      for (int k = 0; k < len; k++) begin
        add_word(rand_sample(), rand_sample(), rand_gain(), rand_pan(), k == len - 1);
      end
      n += len;
    end
    total_words = src_words.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    wait (words_taken == total_words);
    wait (mixes_seen >= mixes_made);
    repeat (SETTLE) @(posedge clk);
    if (mix_expect.size() != 0) begin
      $error("%0d mix words never arrived", mix_expect.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Input driver. Valid stays up until the word is taken; gaps are only
  // chosen right after an accept, never in reaction to in_stall.
  // ---------------------------------------------------------------------------
  source_word_t cur_word;
  int           gap_left  = 0;
  bit           drain_req = 1'b0;  // hold off until every mix word is back
  bit           drain_done = 1'b0;

  always @(posedge clk) begin
    bit tail;
    bit quiet;
    bit closes;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      tail  = (words_taken >= total_words - TAIL_WORDS);
      quiet = (cycle_cnt[9:8] == 2'b01);
      if (in_valid && !in_stall) begin
        closes = mix_source(cur_word);
        if (closes) mixes_made++;
        words_taken <= words_taken + 1;
        if (closes && !drain_done && words_taken + 1 >= DRAIN_AT) begin
          drain_req  = 1'b1;
          drain_done = 1'b1;
        end
        if (!tail && !quiet && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 18);
      end
      if (in_valid && in_stall) begin
        // stalled word holds
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (drain_req && mixes_seen < mixes_made) begin
        in_valid <= 1'b0;
      end else if (src_words.size() != 0) begin
        drain_req       = 1'b0;
        cur_word        = src_words.pop_front();
        in_left_sample  <= cur_word.ls;
        in_right_sample <= cur_word.rs;
        in_source_gain  <= cur_word.gain;
        in_pan_amount   <= cur_word.pan;
        in_last_source  <= cur_word.last;
        in_valid        <= 1'b1;
      end else begin
        drain_req = 1'b0;
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: random bursts, one long hold-off that backs the block up
  // into its input, quiet stretches, and none in the tail.
  // ---------------------------------------------------------------------------
  int hold_left  = 0;
  int burst_left = 0;
  bit hold_done  = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && words_taken >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (words_taken >= total_words - TAIL_WORDS) begin
      out_stall <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (cycle_cnt[9:8] != 2'b10 && $urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(1, 18) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: every taken mix word against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    mix_word_t m;
    if (rst_n && out_valid && !out_stall) begin
      mixes_seen <= mixes_seen + 1;
      if (mix_expect.size() == 0) begin
        $error("unexpected mix word: left %0d right %0d clipped %0b",
               out_mix_left, out_mix_right, out_clipped);
        fail_cnt++;
      end else begin
        m = mix_expect.pop_front();
        if (out_mix_left !== m.left) begin
          $error("mix_left: expected %0d, actual %0d", m.left, out_mix_left);
          fail_cnt++;
        end
        if (out_mix_right !== m.right) begin
          $error("mix_right: expected %0d, actual %0d", m.right, out_mix_right);
          fail_cnt++;
        end
        if (out_clipped !== m.clip) begin
          $error("clipped: expected %0b, actual %0b", m.clip, out_clipped);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles", CYCLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
